// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, pre, post, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/core/rv32_pkg.sv
// ----------------------------------------------------------------------------
// rv32_pkg
// Types, opcodes, status codes and ALU function for the RV32I executor.
// ----------------------------------------------------------------------------
package rv32_pkg;

	localparam logic [6:0] OP_OP     = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [6:0]  F7_ALT    = 7'h20;
	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

	localparam logic [4:0] REG_SP = 5'd2;
	localparam logic [4:0] REG_A0 = 5'd10;
	localparam logic [4:0] REG_A1 = 5'd11;

	localparam logic [31:0] SVC_HEX      = 32'd1;
	localparam logic [31:0] SVC_EXIT     = 32'd10;
	localparam logic [31:0] SVC_CHAR     = 32'd11;
	localparam logic [31:0] SVC_EXIT_VAL = 32'd17;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EXIT     = 3'd1;
	localparam logic [2:0] ST_EXIT_VAL = 3'd2;
	localparam logic [2:0] ST_HEX      = 3'd3;
	localparam logic [2:0] ST_CHAR     = 3'd4;
	localparam logic [2:0] ST_BAD_CALL = 3'd5;
	localparam logic [2:0] ST_ILLEGAL  = 3'd6;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MREQ,
		S_MCAP,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic clr_wr;
		logic mem_rd;
		logic mem_wr;
		logic mem_cap;
		logic cnt_inc;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic mem_op;
		logic is_store;
		logic last_byte;
		logic clr_last;
	} dp_sts_t;

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
			input logic [31:0] a, input logic [31:0] b);
		logic [31:0] r;
		case (f3)
			3'd0: r = alt ? a - b : a + b;
			3'd1: r = a << b[4:0];
			3'd2: r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			3'd3: r = (a < b) ? 32'd1 : 32'd0;
			3'd4: r = a ^ b;
			3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
			3'd6: r = a | b;
			default: r = a & b;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/rv32i_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_executor_core
// RV32I executor: one instruction word in, one status word out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* takes one 32-bit instruction word, executed at the
//   current PC. Master channel m_* returns one word per instruction with
//   the status, the next PC and the ECALL print value (a1).
//   Register and ALU instructions pass through accept, execute and
//   retire. Loads and stores go byte by byte, as the data memory is a
//   single byte-wide RAM port: a load adds a request and a capture step
//   per byte, a store adds a request step per byte.
//   One instruction is in flight at a time; the next word is taken once
//   the previous one has retired into the output register.
//   Reset: the PC and registers clear (sp = memory size) at once; then a
//   clearing pass zeroes data memory, one byte address after another, with s_tready
//   low. A stalled receiver holds the result; the core finishes the next
//   instruction and waits at retire until the output register is free.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor_core import rv32_pkg::*; #(
	parameter int MEM_ADDR_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] instruction_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [2:0] status, [34:3] next_pc, [66:35] print_value
);

	`include "assert_macros.svh"

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [2:0]  status;
	logic [31:0] next_pc, print_value;

	rv32_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	rv32_dp #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_word(s_tdata), .cmd(cmd), .sts(sts),
		.out_status(status), .out_next_pc(next_pc), .out_print(print_value)
	);

	// Pack the result word, lowest field first, pad to whole bytes
	assign m_tdata = {5'd0, print_value, next_pc, status};

	// One word in flight: after an accept, hold off the next
	`ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word taken in flight")
	`ASSERT_IMPLIES(a_status_range, m_tvalid, status <= ST_ILLEGAL, "status out of range")
	`ASSERT_IMPLIES(a_print_zero, m_tvalid && (status == ST_OK || status == ST_ILLEGAL),
		print_value == 32'd0, "print value set without ecall")

endmodule

// File: rtl/core/rv32_ram.sv
// ----------------------------------------------------------------------------
// rv32_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rv32_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/rv32_ctrl.sv
// ----------------------------------------------------------------------------
// rv32_ctrl
// Sequencer: memory clear, accept, execute, byte-serial memory access, retire.
// ----------------------------------------------------------------------------
module rv32_ctrl import rv32_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        can_retire;

	assign can_retire = !out_valid_q || m_tready;
	assign m_tvalid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (s_tvalid) state_d = S_EXEC;
			S_EXEC:  state_d = sts.mem_op ? S_MREQ : S_DONE;
			S_MREQ: begin
				if (!sts.is_store) state_d = S_MCAP;
				else if (sts.last_byte) state_d = S_DONE;
			end
			S_MCAP:  state_d = sts.last_byte ? S_DONE : S_MREQ;
			S_DONE:  if (can_retire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_wr = 1'b1;
			S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			S_EXEC:  cmd.exec = 1'b1;
			S_MREQ: begin
				cmd.mem_rd  = !sts.is_store;
				cmd.mem_wr  = sts.is_store;
				cmd.cnt_inc = sts.is_store && !sts.last_byte;
			end
			S_MCAP: begin
				cmd.mem_cap = 1'b1;
				cmd.cnt_inc = !sts.last_byte;
			end
			S_DONE:  cmd.finish = can_retire;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/rv32_dp.sv
// ----------------------------------------------------------------------------
// rv32_dp
// Datapath: register file, decode and ALU, byte-wide data memory, result.
// ----------------------------------------------------------------------------
module rv32_dp import rv32_pkg::*; #(
	parameter int MEM_ADDR_BITS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] in_word,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic [2:0]  out_status,
	output logic [31:0] out_next_pc,
	output logic [31:0] out_print
);

	localparam logic [31:0] SP_RESET = 32'd1 << MEM_ADDR_BITS;

	logic [31:0] instr_q, pc_q;
	logic [31:0] vld_q;
	logic [4:0]  ra, rb, ra_q, rb_q;
	logic        vld_a_q, vld_b_q;
	logic [31:0] rf_a_raw, rf_b_raw, a, b;

	// Register file read: ECALL reads a0/a1 instead of the rs fields
	assign ra = (in_word[6:0] == OP_SYSTEM) ? REG_A0 : in_word[19:15];
	assign rb = (in_word[6:0] == OP_SYSTEM) ? REG_A1 : in_word[24:20];

	always_ff @(posedge clk) begin
		ra_q    <= ra;
		rb_q    <= rb;
		vld_a_q <= vld_q[ra];
		vld_b_q <= vld_q[rb];
	end

	assign a = vld_a_q ? rf_a_raw : ((ra_q == REG_SP) ? SP_RESET : 32'd0);
	assign b = vld_b_q ? rf_b_raw : ((rb_q == REG_SP) ? SP_RESET : 32'd0);

	// Decode
	logic [6:0]  op, f7;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;

	assign op    = instr_q[6:0];
	assign rd    = instr_q[11:7];
	assign f3    = instr_q[14:12];
	assign f7    = instr_q[31:25];
	assign imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
	assign imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
	assign imm_b = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
		instr_q[11:8], 1'b0};
	assign imm_j = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
		instr_q[30:21], 1'b0};
	assign imm_u = {instr_q[31:12], 12'd0};

	logic [2:0]  x_status;
	logic [31:0] x_npc, x_pv, x_wval, x_addr;
	logic        x_wen, x_load, x_store, take;

	always_comb begin
		x_status = ST_OK;
		x_npc    = pc_q + 32'd4;
		x_pv     = '0;
		x_wen    = 1'b0;
		x_wval   = '0;
		x_load   = 1'b0;
		x_store  = 1'b0;
		x_addr   = a + imm_i;
		take     = 1'b0;
		case (op)
			OP_OP: begin
				if (f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
					x_wen  = 1'b1;
					x_wval = alu(f3, f7 != 7'd0, a, b);
				end else begin
					x_status = ST_ILLEGAL;
				end
			end
			OP_IMM: begin
				if (f3 == 3'd1 && f7 != 7'd0) begin
					x_status = ST_ILLEGAL;
				end else if (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT) begin
					x_status = ST_ILLEGAL;
				end else if (f3 == 3'd1 || f3 == 3'd5) begin
					x_wen  = 1'b1;
					x_wval = alu(f3, f7 == F7_ALT, a, {27'd0, instr_q[24:20]});
				end else begin
					x_wen  = 1'b1;
					x_wval = alu(f3, 1'b0, a, imm_i);
				end
			end
			OP_LOAD: begin
				if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) begin
					x_load = 1'b1;
					x_wen  = 1'b1;
				end else begin
					x_status = ST_ILLEGAL;
				end
			end
			OP_STORE: begin
				x_addr = a + imm_s;
				if (f3 <= 3'd2) x_store = 1'b1;
				else x_status = ST_ILLEGAL;
			end
			OP_BRANCH: begin
				case (f3)
					3'd0: take = (a == b);
					3'd1: take = (a != b);
					3'd4: take = ($signed(a) < $signed(b));
					3'd5: take = ($signed(a) >= $signed(b));
					3'd6: take = (a < b);
					3'd7: take = (a >= b);
					default: x_status = ST_ILLEGAL;
				endcase
				if (take) x_npc = pc_q + imm_b;
			end
			OP_JAL: begin
				x_wen  = 1'b1;
				x_wval = pc_q + 32'd4;
				x_npc  = pc_q + imm_j;
			end
			OP_JALR: begin
				if (f3 != 3'd0) begin
					x_status = ST_ILLEGAL;
				end else begin
					x_npc  = (a + imm_i) & ~32'd1;
					x_wen  = 1'b1;
					x_wval = pc_q + 32'd4;
				end
			end
			OP_LUI: begin
				x_wen  = 1'b1;
				x_wval = imm_u;
			end
			OP_AUIPC: begin
				x_wen  = 1'b1;
				x_wval = pc_q + imm_u;
			end
			OP_SYSTEM: begin
				if (instr_q != ECALL_WORD) begin
					x_status = ST_ILLEGAL;
				end else begin
					x_pv = b;
					case (a)
						SVC_HEX:      x_status = ST_HEX;
						SVC_EXIT:     x_status = ST_EXIT;
						SVC_CHAR:     x_status = ST_CHAR;
						SVC_EXIT_VAL: x_status = ST_EXIT_VAL;
						default:      x_status = ST_BAD_CALL;
					endcase
				end
			end
			default: x_status = ST_ILLEGAL;
		endcase
		if (rd == 5'd0) x_wen = 1'b0;
	end

	// Execute results held for the memory phase and retire
	logic [2:0]  st_q, f3_q;
	logic [31:0] npc_q, pv_q, wval_q, addr_q, sdata_q, acc_q;
	logic [4:0]  rd_q;
	logic        wen_q, ld_q, sto_q;
	logic [1:0]  cnt_q, last_idx;
	logic [MEM_ADDR_BITS-1:0] clr_q, maddr;
	logic [7:0]  mrdata, mwdata;

	always_ff @(posedge clk) begin
		if (cmd.accept) instr_q <= in_word;
		if (cmd.exec) begin
			st_q    <= x_status;
			npc_q   <= x_npc;
			pv_q    <= x_pv;
			wval_q  <= x_wval;
			wen_q   <= x_wen;
			ld_q    <= x_load;
			sto_q   <= x_store;
			addr_q  <= x_addr;
			sdata_q <= b;
			f3_q    <= f3;
			rd_q    <= rd;
			acc_q   <= '0;
		end
		if (cmd.mem_cap) acc_q[{cnt_q, 3'b000} +: 8] <= mrdata;
		if (cmd.finish) begin
			out_status  <= st_q;
			out_next_pc <= npc_q;
			out_print   <= pv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			vld_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.exec) cnt_q <= '0;
			else if (cmd.cnt_inc) cnt_q <= cnt_q + 2'd1;
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cmd.finish) begin
				pc_q <= npc_q;
				if (wen_q) vld_q[rd_q] <= 1'b1;
			end
		end
	end

	assign last_idx = (f3_q[1:0] == 2'd0) ? 2'd0 : ((f3_q[1:0] == 2'd1) ? 2'd1 : 2'd3);

	assign sts.mem_op    = x_load || x_store;
	assign sts.is_store  = sto_q;
	assign sts.last_byte = (cnt_q == last_idx);
	assign sts.clr_last  = &clr_q;

	// Load extension
	logic [31:0] lval, rf_wdata;
	always_comb begin
		case (f3_q)
			3'd0:    lval = {{24{acc_q[7]}}, acc_q[7:0]};
			3'd1:    lval = {{16{acc_q[15]}}, acc_q[15:0]};
			3'd4:    lval = {24'd0, acc_q[7:0]};
			3'd5:    lval = {16'd0, acc_q[15:0]};
			default: lval = acc_q;
		endcase
	end
	assign rf_wdata = ld_q ? lval : wval_q;

	rv32_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk(clk), .we(cmd.finish && wen_q), .waddr(rd_q), .wdata(rf_wdata),
		.raddr(ra), .rdata(rf_a_raw)
	);

	rv32_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk(clk), .we(cmd.finish && wen_q), .waddr(rd_q), .wdata(rf_wdata),
		.raddr(rb), .rdata(rf_b_raw)
	);

	// Byte-wide data memory; each byte address wraps separately
	assign maddr  = cmd.clr_wr ? clr_q : addr_q[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(cnt_q);
	assign mwdata = cmd.clr_wr ? 8'd0 : 8'(sdata_q >> {cnt_q, 3'b000});

	rv32_ram #(.WIDTH(8), .DEPTH(1 << MEM_ADDR_BITS)) u_dmem (
		.clk(clk), .we(cmd.clr_wr || cmd.mem_wr), .waddr(maddr), .wdata(mwdata),
		.raddr(maddr), .rdata(mrdata)
	);

endmodule
